>>> design/rgb_to_hsl_convert_defines.svh
// Assertion macros for the RGB to HSL converter checks
`ifndef RGB_TO_HSL_CONVERT_DEFINES_SVH
`define RGB_TO_HSL_CONVERT_DEFINES_SVH

// Plain property, sampled on the clock, off while reset is asserted
`define RHC_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rhc_checker: property failed");

// Implication from an antecedent to a consequent
`define RHC_CHECK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rhc_checker: implication failed");

`endif

>>> design/rhc_pkg.sv
// Shared widths, constants and reciprocal table for the RGB to HSL converter
`default_nettype none

package rhc_pkg;

    localparam int CH_W      = 8;   // input channel width
    localparam int HUE_W     = 12;  // hue in tenths of a degree
    localparam int PCT_W     = 10;  // saturation / lightness in tenths of a percent
    localparam int NUM_W     = 20;  // halved rounding numerator
    localparam int DVS_W     = 9;   // divisor width (up to 510)
    localparam int RCP_SHIFT = 20;  // reciprocal scale 2^20
    localparam int RCP_W     = RCP_SHIFT + 1;
    localparam int Q_W       = 12;  // quotient width (up to 3600)
    localparam int PROD_W    = NUM_W + RCP_W;
    localparam int BACK_W    = Q_W + DVS_W;

    localparam int LATENCY   = 6;

    localparam int NUM_LANES = 3;
    localparam int LANE_HUE  = 0;
    localparam int LANE_SAT  = 1;
    localparam int LANE_LIG  = 2;

    localparam logic [1:0] SEC_RED = 2'd0;
    localparam logic [1:0] SEC_GRN = 2'd1;
    localparam logic [1:0] SEC_BLU = 2'd2;

    localparam logic [HUE_W-1:0] HUE_TURN = 12'd3600;
    localparam logic [PCT_W-1:0] PCT_FULL = 10'd1000;

    localparam logic [DVS_W-1:0] LIG_DVS   = 9'd510;
    localparam logic [RCP_W-1:0] LIG_RECIP = RCP_W'((1 << RCP_SHIFT) / 510);

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DVS_W-1:0] dvs;
    } t_div_op;

    typedef logic [255:0][RCP_W-1:0] t_recip_tbl;

    // floor(2^20 / d) for d = 1..255 by long division; entry 0 is unused
    function automatic t_recip_tbl build_recip_tbl();
        t_recip_tbl       tbl;
        logic [9:0]       rem;
        logic [RCP_W-1:0] quo;
        tbl = '0;
        for (int d = 1; d < 256; d++) begin
            rem = '0;
            quo = '0;
            for (int i = RCP_SHIFT; i >= 0; i--) begin
                rem = {rem[8:0], (i == RCP_SHIFT) ? 1'b1 : 1'b0};
                if (rem >= 10'(d)) begin
                    rem    = rem - 10'(d);
                    quo[i] = 1'b1;
                end
            end
            tbl[d] = quo;
        end
        return tbl;
    endfunction

    localparam t_recip_tbl RECIP_TBL = build_recip_tbl();

endpackage

`default_nettype wire

>>> design/rgb_to_hsl_convert.sv
// RGB to HSL converter: six-stage pipeline with reciprocal-multiply dividers
//
// Usage: drive i_red/i_green/i_blue and raise start; a pixel is taken at a
// rising edge where start is high and busy is low. busy is high only in
// reset and for the first cycle after it, so one pixel per clock enters.
// Each result shows on o_hue, o_saturation and o_lightness for exactly one
// cycle with o_valid high, after passing the stage registers s1 to s5 and
// the output register, in input order.
// Throughput: one pixel per cycle while busy is low, back to back.
// After the channel compare come the steps of the division path: numerator build, reciprocal
// table read, 20x21 multiply, quotient times divisor, then a one-step
// correction and the 3600 wrap, each in its own register stage.
// Reset (synchronous, active low) empties the pipeline; pixels in flight
// are dropped and no result follows them. The receiver cannot stall: a
// result is taken in the cycle it is shown.
// Hue is in tenths of a degree (0..3599), saturation and lightness in
// tenths of a percent (0..1000), all rounded to nearest, halves up.
`default_nettype none

module rgb_to_hsl_convert (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [rhc_pkg::CH_W-1:0]  i_red,
    input  logic [rhc_pkg::CH_W-1:0]  i_green,
    input  logic [rhc_pkg::CH_W-1:0]  i_blue,
    output logic                      o_valid,
    output logic [rhc_pkg::HUE_W-1:0] o_hue,
    output logic [rhc_pkg::PCT_W-1:0] o_saturation,
    output logic [rhc_pkg::PCT_W-1:0] o_lightness
);
    import rhc_pkg::*;

    logic r_busy;
    logic in_acc;

    // stage 1: channel compare
    logic                    r_s1_vld;
    logic [CH_W-1:0]         r_s1_delta;
    logic [CH_W:0]           r_s1_sum;
    logic [1:0]              r_s1_sec;
    logic signed [CH_W:0]    r_s1_diff;
    logic [CH_W-1:0]         n_max;
    logic [CH_W-1:0]         n_min;
    logic [1:0]              n_sec;
    logic signed [CH_W:0]    n_diff;

    // stage 2: numerators and divisors
    logic                          r_s2_vld;
    logic                          r_s2_gray;
    t_div_op [NUM_LANES-1:0]       r_s2_op;
    t_div_op [NUM_LANES-1:0]       n_s2_op;
    logic [CH_W-1:0]               n_den;
    logic [HUE_W-1:0]              n_base;
    logic signed [21:0]            n_t;

    // stage 3: reciprocals
    logic                          r_s3_vld;
    logic                          r_s3_gray;
    t_div_op [NUM_LANES-1:0]       r_s3_op;
    logic [NUM_LANES-1:0][RCP_W-1:0] r_s3_rcp;

    // stage 4: estimated quotients
    logic                          r_s4_vld;
    logic                          r_s4_gray;
    t_div_op [NUM_LANES-1:0]       r_s4_op;
    logic [NUM_LANES-1:0][Q_W-1:0] r_s4_q0;
    logic [NUM_LANES-1:0][PROD_W-1:0] n_s4_prod;

    // stage 5: quotient times divisor
    logic                            r_s5_vld;
    logic                            r_s5_gray;
    t_div_op [NUM_LANES-1:0]         r_s5_op;
    logic [NUM_LANES-1:0][Q_W-1:0]   r_s5_q0;
    logic [NUM_LANES-1:0][BACK_W-1:0] r_s5_back;

    // stage 6: corrected quotients
    logic [NUM_LANES-1:0][Q_W-1:0]   n_q;
    logic [HUE_W-1:0]                n_hue;

    assign busy   = r_busy;
    assign in_acc = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_comb begin
        n_min = (i_red <= i_green) ? i_red : i_green;
        n_min = (i_blue < n_min) ? i_blue : n_min;
        if (i_red >= i_green && i_red >= i_blue) begin
            n_max  = i_red;
            n_sec  = SEC_RED;
            n_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            n_max  = i_green;
            n_sec  = SEC_GRN;
            n_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_max  = i_blue;
            n_sec  = SEC_BLU;
            n_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    always_comb begin
        if (r_s1_sum <= 9'd255) begin
            n_den = r_s1_sum[CH_W-1:0];
        end else begin
            n_den = CH_W'(9'd510 - r_s1_sum);
        end
        unique case (r_s1_sec)
            SEC_RED: n_base = r_s1_diff[CH_W] ? 12'd3600 : 12'd0;
            SEC_GRN: n_base = 12'd1200;
            SEC_BLU: n_base = 12'd2400;
            default: n_base = 12'd0;
        endcase
        n_t = ($signed({{13{r_s1_diff[CH_W]}}, r_s1_diff}) * 22'sd600)
            + $signed({2'b00, 20'(n_base * r_s1_delta)});

        // halved rounding numerators: floor((2n + d) / 2)
        n_s2_op[LANE_HUE].num = n_t[NUM_W-1:0] + NUM_W'(r_s1_delta[CH_W-1:1]);
        n_s2_op[LANE_HUE].dvs = {1'b0, r_s1_delta};
        n_s2_op[LANE_SAT].num = NUM_W'(r_s1_delta * 10'd1000) + NUM_W'(n_den[CH_W-1:1]);
        n_s2_op[LANE_SAT].dvs = {1'b0, n_den};
        n_s2_op[LANE_LIG].num = NUM_W'(r_s1_sum * 10'd1000) + NUM_W'(255);
        n_s2_op[LANE_LIG].dvs = LIG_DVS;
    end

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            n_s4_prod[k] = r_s3_op[k].num * r_s3_rcp[k];
        end
    end

    // estimate is the true quotient or one below it; add one where the
    // remainder still reaches the divisor
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            if ({2'b00, r_s5_op[k].num} >= ({1'b0, r_s5_back[k]} + 22'(r_s5_op[k].dvs))) begin
                n_q[k] = r_s5_q0[k] + Q_W'(1);
            end else begin
                n_q[k] = r_s5_q0[k];
            end
        end
        n_hue = (n_q[LANE_HUE] >= HUE_TURN) ? n_q[LANE_HUE] - HUE_TURN : n_q[LANE_HUE];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_s1_vld <= in_acc;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            o_valid  <= r_s5_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_s1_delta <= n_max - n_min;
        r_s1_sum   <= {1'b0, n_max} + {1'b0, n_min};
        r_s1_sec   <= n_sec;
        r_s1_diff  <= n_diff;

        r_s2_op   <= n_s2_op;
        r_s2_gray <= (r_s1_delta == '0);

        r_s3_op   <= r_s2_op;
        r_s3_gray <= r_s2_gray;
        r_s3_rcp[LANE_HUE] <= RECIP_TBL[r_s2_op[LANE_HUE].dvs[CH_W-1:0]];
        r_s3_rcp[LANE_SAT] <= RECIP_TBL[r_s2_op[LANE_SAT].dvs[CH_W-1:0]];
        r_s3_rcp[LANE_LIG] <= LIG_RECIP;

        r_s4_op   <= r_s3_op;
        r_s4_gray <= r_s3_gray;
        for (int k = 0; k < NUM_LANES; k++) begin
            r_s4_q0[k] <= n_s4_prod[k][RCP_SHIFT +: Q_W];
        end

        r_s5_op   <= r_s4_op;
        r_s5_gray <= r_s4_gray;
        r_s5_q0   <= r_s4_q0;
        for (int k = 0; k < NUM_LANES; k++) begin
            r_s5_back[k] <= r_s4_q0[k] * r_s4_op[k].dvs;
        end

        // grey pixel: drop hue and saturation
        o_hue        <= r_s5_gray ? '0 : n_hue;
        o_saturation <= r_s5_gray ? '0 : n_q[LANE_SAT][PCT_W-1:0];
        o_lightness  <= n_q[LANE_LIG][PCT_W-1:0];
    end

endmodule

`default_nettype wire

>>> design/rhc_checker.sv
// Port-level checks for the RGB to HSL converter, bound to the top level
`default_nettype none
`include "rgb_to_hsl_convert_defines.svh"

module rhc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [rhc_pkg::CH_W-1:0]  i_red,
    input logic [rhc_pkg::CH_W-1:0]  i_green,
    input logic [rhc_pkg::CH_W-1:0]  i_blue,
    input logic                      o_valid,
    input logic [rhc_pkg::HUE_W-1:0] o_hue,
    input logic [rhc_pkg::PCT_W-1:0] o_saturation,
    input logic [rhc_pkg::PCT_W-1:0] o_lightness
);
    import rhc_pkg::*;

    logic in_acc;
    logic pix_grey;

    assign in_acc   = start && !busy;
    assign pix_grey = (i_red == i_green) && (i_green == i_blue);

    // every transaction yields a result after the fixed latency
    `RHC_CHECK_IMPL(a_latency, in_acc, ##LATENCY o_valid)
    // no result without a transaction the fixed latency earlier
    `RHC_CHECK_IMPL(a_no_spurious, o_valid, $past(in_acc, LATENCY))
    `RHC_CHECK_IMPL(a_range, o_valid, o_hue < HUE_TURN && o_saturation <= PCT_FULL && o_lightness <= PCT_FULL)
    // zero saturation only comes from a grey pixel, which has zero hue
    `RHC_CHECK_IMPL(a_grey, o_valid && o_saturation == '0, o_hue == '0 && $past(pix_grey, LATENCY))
    `RHC_CHECK(a_busy_after_reset, $past(!i_rst_n) |-> busy)

endmodule

bind rgb_to_hsl_convert rhc_checker u_rhc_checker (.*);

`default_nettype wire
